// ===== rtl/atac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-axis accelerometer conditioner: shared definitions
// Types, widths and codes used by the controller, the datapath and the top.
// ----------------------------------------------------------------------------
package atac_pkg;

  localparam int NUM_AXES   = 3;
  localparam int WORD_W     = 16;
  localparam int SAMP_W     = 12;  // sample after the arithmetic shift by four
  localparam int OFF_W      = 12;  // offset magnitude, 0 to 2048
  localparam int FILT_W     = 13;  // filter state and corrected sample, signed
  localparam int SUM_W      = 18;  // calibration sum, signed
  localparam int CNT_W      = 6;   // calibration count
  localparam int ACC_W      = 23;  // alpha * v + (256 - alpha) * f
  localparam int PROD_W     = 27;  // f * output_scale
  localparam int OUT_W      = 14;
  localparam int STATUS_W   = 2;

  // Reciprocal divide of a sum magnitude by the sample count. With a dividend
  // below 2^SUM_W and a count of at most 64, a shift of SUM_W + 6 is exact.
  localparam int RECIP_SHIFT  = SUM_W + CNT_W;
  localparam int RECIP_W      = RECIP_SHIFT + 1;
  localparam int RECIP_PROD_W = SUM_W + RECIP_W;

  localparam int ALPHA_W    = 9;
  localparam int LIMIT_W    = 12;
  localparam int SCALE_W    = 13;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;

  localparam int FILT_SHIFT  = 8;
  localparam int SCALE_SHIFT = 12;

  localparam logic [ALPHA_W-1:0] ALPHA_FULL  = 9'd256;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd26;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd30;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 13'd5023;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STAT_VALID     = 2'd0,
    STAT_READ_FAIL = 2'd1,
    STAT_CAL_TAKEN = 2'd2,
    STAT_CAL_ABORT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ABORT,
    S_CAL,
    S_DIV_LOAD,
    S_DIV,
    S_OFFSET,
    S_FILT,
    S_CLIP,
    S_SCALE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    accumulate;
    logic    clear_cal;
    logic    div_start;
    logic    load_offsets;
    logic    filt;
    logic    clip;
    logic    scale;
    logic    load_out;
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

endpackage

// ===== rtl/atac_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conditioner controller
// Sequences calibration, offset division and the filter lanes, and owns the
// mode bit, the calibration count and the result valid flag.
// ----------------------------------------------------------------------------
module atac_ctrl
  import atac_pkg::*;
#(
  parameter int CAL_SAMPLES = 50
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  sample_valid,
  output logic  sample_stall,
  input  logic  read_failed,
  output logic  result_valid,
  input  logic  result_stall,
  output cmd_t  cmd,
  input  stat_t stat
);

  state_t           state;
  state_t           state_next;
  logic             running;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_inc;
  status_t          code;
  logic             accept;
  logic             out_free;
  logic             cal_last;

  assign accept    = sample_valid && !sample_stall;
  assign out_free  = !result_valid || !result_stall;
  assign count_inc = count + CNT_W'(1);
  assign cal_last  = count_inc >= CNT_W'(CAL_SAMPLES);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (!running) begin
            state_next = read_failed ? S_ABORT : S_CAL;
          end else begin
            state_next = read_failed ? S_EMIT : S_FILT;
          end
        end
      end
      S_ABORT:    state_next = S_EMIT;
      S_CAL:      state_next = cal_last ? S_DIV_LOAD : S_EMIT;
      S_DIV_LOAD: state_next = S_DIV;
      S_DIV:      state_next = stat.div_done ? S_OFFSET : S_DIV;
      S_OFFSET:   state_next = S_EMIT;
      S_FILT:     state_next = S_CLIP;
      S_CLIP:     state_next = S_SCALE;
      S_SCALE:    state_next = S_EMIT;
      S_EMIT:     state_next = out_free ? S_IDLE : S_EMIT;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd              = '0;
    cmd.code         = code;
    cmd.capture      = accept;
    cmd.clear_cal    = (state == S_ABORT);
    cmd.accumulate   = (state == S_CAL);
    cmd.div_start    = (state == S_DIV_LOAD);
    cmd.load_offsets = (state == S_OFFSET);
    cmd.filt         = (state == S_FILT);
    cmd.clip         = (state == S_CLIP);
    cmd.scale        = (state == S_SCALE);
    cmd.load_out     = (state == S_EMIT) && out_free;
    sample_stall     = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      running      <= 1'b0;
      count        <= '0;
      code         <= STAT_VALID;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && accept) begin
        if (!running) begin
          code <= read_failed ? STAT_CAL_ABORT : STAT_CAL_TAKEN;
        end else begin
          code <= read_failed ? STAT_READ_FAIL : STAT_VALID;
        end
      end
      if (state == S_ABORT) begin
        running <= 1'b1;
        count   <= '0;
      end
      if (state == S_CAL) begin
        count <= count_inc;
      end
      if (state == S_OFFSET) begin
        running <= 1'b1;
      end
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  // Once running, the block never goes back to calibrating.
  assert property (@(posedge clk) disable iff (rst) running |=> running)
    else $error("running mode dropped");

  // A new result only ever appears from the emit step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_EMIT)
    else $error("result raised outside emit");

  // The calibration count never passes the sample target.
  assert property (@(posedge clk) disable iff (rst)
    !running |-> count <= CNT_W'(CAL_SAMPLES))
    else $error("calibration count overran");
`endif

endmodule

// ===== rtl/atac_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conditioner datapath
// Three axis lanes with calibration sums, a reciprocal offset divider, the
// exponential filter with dead band, output scaling and the result register.
// ----------------------------------------------------------------------------
module atac_dp
  import atac_pkg::*;
#(
  parameter int CAL_SAMPLES = 50
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic [WORD_W-1:0]           word_x,
  input  logic [WORD_W-1:0]           word_y,
  input  logic [WORD_W-1:0]           word_z,
  input  cmd_t                        cmd,
  output stat_t                       stat,
  output logic signed [OUT_W-1:0]     accel_x,
  output logic signed [OUT_W-1:0]     accel_y,
  output logic signed [OUT_W-1:0]     accel_z,
  output logic [STATUS_W-1:0]         status
);

  // Rounded-up reciprocal of the sample count, scaled by 2^RECIP_SHIFT.
  localparam logic [RECIP_W-1:0] CAL_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(CAL_SAMPLES - 1)) / 64'(CAL_SAMPLES));

  logic [ALPHA_W-1:0] filter_alpha;
  logic [LIMIT_W-1:0] deadband_limit;
  logic [SCALE_W-1:0] output_scale;

  logic [ALPHA_W-1:0] alpha_sat;
  logic [ALPHA_W-1:0] alpha_rest;

  logic [WORD_W-1:0]        words      [NUM_AXES];
  logic signed [SAMP_W-1:0] samp       [NUM_AXES];
  logic signed [SUM_W-1:0]  sums       [NUM_AXES];
  logic [OFF_W-1:0]         offsets    [NUM_AXES];
  logic signed [FILT_W-1:0] filt       [NUM_AXES];
  logic signed [ACC_W-1:0]  acc        [NUM_AXES];
  logic signed [PROD_W-1:0] prod       [NUM_AXES];
  logic [SUM_W-1:0]         quo        [NUM_AXES];

  logic signed [FILT_W-1:0] corr       [NUM_AXES];
  logic signed [ACC_W-1:0]  acc_next   [NUM_AXES];
  logic signed [ACC_W-1:0]  acc_shift  [NUM_AXES];
  logic signed [FILT_W-1:0] clipped    [NUM_AXES];
  logic [FILT_W-1:0]        mag        [NUM_AXES];
  logic signed [PROD_W-1:0] prod_next  [NUM_AXES];
  logic [SUM_W-1:0]         sum_abs    [NUM_AXES];
  logic [RECIP_PROD_W-1:0]  recip_prod [NUM_AXES];

  logic quo_ready;

  assign words[0] = word_x;
  assign words[1] = word_y;
  assign words[2] = word_z;

  // Alpha above full weight saturates to full weight.
  assign alpha_sat  = filter_alpha[ALPHA_W-1] ? ALPHA_FULL : filter_alpha;
  assign alpha_rest = ALPHA_FULL - alpha_sat;

  assign stat.div_done = quo_ready;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      // A positive sample has the offset taken off, anything else has it added.
      if (samp[i] > 0) begin
        corr[i] = FILT_W'(samp[i]) - $signed({1'b0, offsets[i]});
      end else begin
        corr[i] = FILT_W'(samp[i]) + $signed({1'b0, offsets[i]});
      end
      acc_next[i] = ACC_W'($signed({1'b0, alpha_sat})) * ACC_W'(corr[i])
                  + ACC_W'($signed({1'b0, alpha_rest})) * ACC_W'(filt[i]);

      // Divide by 256 with truncation toward zero.
      if (acc[i] < 0) begin
        acc_shift[i] = (acc[i] + ACC_W'(255)) >>> FILT_SHIFT;
      end else begin
        acc_shift[i] = acc[i] >>> FILT_SHIFT;
      end
      clipped[i] = acc_shift[i][FILT_W-1:0];
      mag[i]     = clipped[i][FILT_W-1] ? FILT_W'(-clipped[i]) : FILT_W'(clipped[i]);

      prod_next[i] = PROD_W'(filt[i]) * PROD_W'($signed({1'b0, output_scale}));

      sum_abs[i]    = sums[i][SUM_W-1] ? SUM_W'(-sums[i]) : SUM_W'(sums[i]);
      recip_prod[i] = RECIP_PROD_W'(sum_abs[i]) * RECIP_PROD_W'(CAL_RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_alpha   <= ALPHA_RESET;
      deadband_limit <= LIMIT_RESET;
      output_scale   <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALPHA:    filter_alpha   <= cfg_data[ALPHA_W-1:0];
        CFG_DEADBAND: deadband_limit <= cfg_data[LIMIT_W-1:0];
        CFG_SCALE:    output_scale   <= cfg_data[SCALE_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        sums[i]    <= '0;
        offsets[i] <= '0;
        filt[i]    <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_AXES; i++) begin
        if (cmd.clear_cal) begin
          sums[i]    <= '0;
          offsets[i] <= '0;
        end else if (cmd.accumulate) begin
          sums[i] <= sums[i] + SUM_W'(samp[i]);
        end
        if (cmd.load_offsets) begin
          offsets[i] <= quo[i][OFF_W-1:0];
        end
        if (cmd.clip) begin
          filt[i] <= ($signed({1'b0, mag[i]}) < $signed({2'b0, deadband_limit}))
                     ? '0 : clipped[i];
        end
      end
    end
  end

  // The quotients are ready the cycle after the divide starts.
  always_ff @(posedge clk) begin
    if (rst) begin
      quo_ready <= 1'b0;
    end else begin
      quo_ready <= cmd.div_start;
    end
  end

  // Payload registers: samples, filter accumulators, products and quotients.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (cmd.capture) begin
        samp[i] <= words[i][WORD_W-1:WORD_W-SAMP_W];
      end
      if (cmd.filt) begin
        acc[i] <= acc_next[i];
      end
      if (cmd.scale) begin
        prod[i] <= prod_next[i];
      end
      if (cmd.div_start) begin
        quo[i] <= recip_prod[i][RECIP_SHIFT +: SUM_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status <= cmd.code;
      if (cmd.code == STAT_VALID) begin
        accel_x <= prod[0][SCALE_SHIFT+OUT_W-1:SCALE_SHIFT];
        accel_y <= prod[1][SCALE_SHIFT+OUT_W-1:SCALE_SHIFT];
        accel_z <= prod[2][SCALE_SHIFT+OUT_W-1:SCALE_SHIFT];
      end else begin
        accel_x <= '0;
        accel_y <= '0;
        accel_z <= '0;
      end
    end
  end

`ifndef SYNTH
  // The filter state is a blend of values that never exceed 2048 in magnitude.
  assert property (@(posedge clk) disable iff (rst)
    filt[0] >= -2048 && filt[0] <= 2048 && filt[1] >= -2048 && filt[1] <= 2048
    && filt[2] >= -2048 && filt[2] <= 2048)
    else $error("filter state out of range");

  // The quotient of a full calibration has no bits set above bit OFF_W.
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_offsets |-> quo[0][SUM_W-1:OFF_W+1] == '0 && quo[1][SUM_W-1:OFF_W+1] == '0
    && quo[2][SUM_W-1:OFF_W+1] == '0)
    else $error("offset quotient too large");

  // A calibration sum never holds more than CAL_SAMPLES full-scale samples.
  assert property (@(posedge clk) disable iff (rst)
    sum_abs[0] <= SUM_W'(2048 * CAL_SAMPLES) && sum_abs[1] <= SUM_W'(2048 * CAL_SAMPLES)
    && sum_abs[2] <= SUM_W'(2048 * CAL_SAMPLES))
    else $error("calibration sum out of range");
`endif

endmodule

// ===== rtl/accel_three_axis_conditioner_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-axis accelerometer conditioner
// Offset calibration, exponential filter with dead band and output scaling.
// ----------------------------------------------------------------------------
// Each accepted beat carries three left-justified sensor words and a failed
// read flag, and yields exactly one result beat. After reset the first
// CAL_SAMPLES good beats are summed per axis and each axis offset becomes the
// magnitude of the truncated mean; a failed read during calibration aborts it
// with zero offsets. The controller sequences the three parallel axis
// lanes: a good beat while running goes from acceptance to the result
// register through correct and filter, truncate and dead band, scale
// and load; a failed read while running goes straight to the load; a
// calibration beat passes through its accumulate step and an abort
// through its clear step before the load; and the final calibration beat
// forms each offset by a reciprocal multiply of the sum magnitude, a wait
// for the quotient and an offset load before the result load. The load
// of a finished result waits while the previous one is held by
// result_stall. The next beat is taken the cycle after the result register
// loads. A new beat is taken as soon as the block is back in idle, even
// while the previous result is still held waiting on result_stall.
// Configuration writes are always ready and take effect at once.
// ----------------------------------------------------------------------------
module accel_three_axis_conditioner_unit
  import atac_pkg::*;
#(
  parameter int CAL_SAMPLES = 50
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    sample_valid,
  output logic                    sample_stall,
  input  logic [WORD_W-1:0]       word_x,
  input  logic [WORD_W-1:0]       word_y,
  input  logic [WORD_W-1:0]       word_z,
  input  logic                    read_failed,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic signed [OUT_W-1:0] accel_x,
  output logic signed [OUT_W-1:0] accel_y,
  output logic signed [OUT_W-1:0] accel_z,
  output logic [STATUS_W-1:0]     status
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  atac_ctrl #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .read_failed  (read_failed),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .stat         (stat)
  );

  atac_dp #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .word_x    (word_x),
    .word_y    (word_y),
    .word_z    (word_z),
    .cmd       (cmd),
    .stat      (stat),
    .accel_x   (accel_x),
    .accel_y   (accel_y),
    .accel_z   (accel_z),
    .status    (status)
  );

endmodule

// ===== test/tb_accel_three_axis_conditioner_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the three-axis accelerometer conditioner
// Calibrates the block, drives directed field and register extremes, and then
// random sensor traffic under three idling profiles. Each result beat is
// compared field by field with an in-bench prediction of the block.
// ----------------------------------------------------------------------------
module tb_accel_three_axis_conditioner_unit;
  import atac_pkg::*;

  localparam int CAL_BEATS = 50;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [NUM_AXES-1:0][OUT_W-1:0] accel;
    status_t                        code;
  } accel_beat_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    sample_valid = 1'b0;
  logic                    sample_stall;
  logic [WORD_W-1:0]       word_x = '0;
  logic [WORD_W-1:0]       word_y = '0;
  logic [WORD_W-1:0]       word_z = '0;
  logic                    read_failed = 1'b0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic signed [OUT_W-1:0] accel_x;
  logic signed [OUT_W-1:0] accel_y;
  logic signed [OUT_W-1:0] accel_z;
  logic [STATUS_W-1:0]     status;

  // Predicted state of the block and its registers.
  int filt_state [NUM_AXES];
  int offset_mag [NUM_AXES];
  int cal_sum [NUM_AXES];
  int cal_count;
  bit running;
  int alpha_reg;
  int deadband_reg;
  int scale_reg;

  accel_beat_t pending_results [$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  int          gravity_bias [NUM_AXES];
  string       axis_label [NUM_AXES] = '{"accel_x", "accel_y", "accel_z"};

  accel_three_axis_conditioner_unit #(
    .CAL_SAMPLES(CAL_BEATS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .word_x       (word_x),
    .word_y       (word_y),
    .word_z       (word_z),
    .read_failed  (read_failed),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .accel_z      (accel_z),
    .status       (status)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Computes the result beat for one accepted sensor beat and advances the
  // predicted state.
  function automatic accel_beat_t condition_sample(logic [NUM_AXES-1:0][WORD_W-1:0] words,
                                                   logic failed);
    accel_beat_t r;
    int          s [NUM_AXES];
    int          a;
    int          v;
    int          f;
    int          m;
    longint      p;
    r.accel = '0;
    for (int i = 0; i < NUM_AXES; i++) s[i] = int'($signed(words[i])) >>> 4;
    if (!running) begin
      if (failed) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          offset_mag[i] = 0;
          cal_sum[i] = 0;
        end
        cal_count = 0;
        running = 1'b1;
        r.code = STAT_CAL_ABORT;
      end else begin
        for (int i = 0; i < NUM_AXES; i++) cal_sum[i] += s[i];
        cal_count = (cal_count + 1) & 63;
        if (cal_count >= CAL_BEATS) begin
          for (int i = 0; i < NUM_AXES; i++) begin
            m = cal_sum[i] / CAL_BEATS;
            offset_mag[i] = (m < 0) ? -m : m;
          end
          running = 1'b1;
        end
        r.code = STAT_CAL_TAKEN;
      end
    end else if (failed) begin
      r.code = STAT_READ_FAIL;
    end else begin
      a = (alpha_reg > 256) ? 256 : alpha_reg;
      for (int i = 0; i < NUM_AXES; i++) begin
        v = (s[i] > 0) ? s[i] - offset_mag[i] : s[i] + offset_mag[i];
        // Integer division truncates toward zero, as the filter requires.
        f = (a * v + (256 - a) * filt_state[i]) / 256;
        if (((f < 0) ? -f : f) < deadband_reg) f = 0;
        filt_state[i] = f;
        p = longint'(f) * longint'(scale_reg);
        p = p >>> SCALE_SHIFT;
        r.accel[i] = p[OUT_W-1:0];
      end
      r.code = STAT_VALID;
    end
    return r;
  endfunction

  // Forms a left-justified sensor word from a 12-bit sample, clamped to range.
  function automatic logic [WORD_W-1:0] sensor_word(int sample);
    int c;
    logic [SAMP_W-1:0] q;
    c = (sample > 2047) ? 2047 : ((sample < -2048) ? -2048 : sample);
    q = c[SAMP_W-1:0];
    return {q, 4'($urandom_range(15))};
  endfunction

  task automatic send_beat(logic [WORD_W-1:0] wx, logic [WORD_W-1:0] wy,
                           logic [WORD_W-1:0] wz, logic failed);
    while ($urandom_range(99) < send_gap_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    word_x <= wx;
    word_y <= wy;
    word_z <= wz;
    read_failed <= failed;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    pending_results.push_back(condition_sample({wz, wy, wx}, failed));
  endtask

  // A sensor beat near the calibrated rest point, with noise of random reach.
  task automatic send_realistic_beat();
    logic [WORD_W-1:0] w [NUM_AXES];
    int reach;
    reach = ($urandom_range(3) == 0) ? 2048 : $urandom_range(200);
    for (int i = 0; i < NUM_AXES; i++)
      w[i] = sensor_word(gravity_bias[i] + $urandom_range(2 * reach) - reach);
    send_beat(w[0], w[1], w[2], 1'b0);
  endtask

  task automatic send_noise_beat();
    send_beat(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic drain_results();
    sample_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    // Waiting for an edge with valid low keeps the next write from driving valid in this step.
    @(posedge clk);
    case (idx)
      CFG_ALPHA:    alpha_reg = int'(data[ALPHA_W-1:0]);
      CFG_DEADBAND: deadband_reg = int'(data[LIMIT_W-1:0]);
      CFG_SCALE:    scale_reg = int'(data[SCALE_W-1:0]);
      default:      ;
    endcase
  endtask

  // Result side: random stall and in-order comparison of every accepted beat.
  always @(posedge clk) begin
    accel_beat_t want;
    logic [NUM_AXES-1:0][OUT_W-1:0] got;
    if (!rst && result_valid && !result_stall) begin
      got = {accel_z, accel_y, accel_x};
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation: status %0d", status);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        for (int i = 0; i < NUM_AXES; i++) begin
          if (got[i] !== want.accel[i]) begin
            $error("%s expected %0d got %0d", axis_label[i],
                   $signed(want.accel[i]), $signed(got[i]));
            fail_count++;
          end
        end
        if (status !== want.code) begin
          $error("status expected %0d got %0d", want.code, status);
          fail_count++;
        end
      end
    end
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // The first CAL_BEATS good beats set the offsets; a failed read sometimes
  // aborts the calibration partway through.
  task automatic test_calibration();
    bit abort_cal;
    int abort_at;
    logic [WORD_W-1:0] w [NUM_AXES];
    abort_cal = ($urandom_range(3) == 0);
    abort_at = $urandom_range(CAL_BEATS - 1);
    for (int i = 0; i < NUM_AXES; i++)
      gravity_bias[i] = $urandom_range(3000) - 1500;
    for (int k = 0; k < CAL_BEATS; k++) begin
      if (abort_cal && k == abort_at) begin
        send_beat(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
        break;
      end
      for (int i = 0; i < NUM_AXES; i++)
        w[i] = sensor_word(gravity_bias[i] + $urandom_range(80) - 40);
      send_beat(w[0], w[1], w[2], 1'b0);
    end
  endtask

  task automatic test_reset_registers();
    send_realistic_beat();
    send_beat(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
    send_realistic_beat();
    send_realistic_beat();
  endtask

  task automatic test_word_extremes();
    send_beat(16'h0000, 16'h7FFF, 16'h8000, 1'b0);
    send_beat(16'hFFFF, 16'h000F, 16'hFFF0, 1'b0);
    send_beat(16'h0010, 16'hFFEF, 16'h7FF0, 1'b0);
    send_beat(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_beat(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_beat(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_beat(16'h0000, 16'h0000, 16'h0000, 1'b1);
  endtask

  task automatic test_register_extremes();
    drain_results();
    write_register(CFG_ALPHA, 13'd256);
    write_register(CFG_DEADBAND, 13'd0);
    write_register(CFG_SCALE, 13'd8191);
    send_beat(16'h7FFF, 16'h8000, 16'h0010, 1'b0);
    send_beat(16'h8000, 16'h7FFF, 16'hFFF0, 1'b0);
    drain_results();
    // Alpha is nine bits wide: the write keeps 511, which saturates to 256.
    write_register(CFG_ALPHA, 13'h1FFF);
    write_register(CFG_SCALE, 13'd0);
    send_realistic_beat();
    send_beat(16'h7FFF, 16'h7FFF, 16'h8000, 1'b0);
    drain_results();
    write_register(CFG_ALPHA, 13'd0);
    write_register(CFG_SCALE, 13'd5023);
    send_realistic_beat();
    send_realistic_beat();
    drain_results();
    // A dead band above 2048 clears every filtered value.
    write_register(CFG_DEADBAND, 13'h1FFF);
    write_register(CFG_ALPHA, 13'd128);
    send_beat(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
    send_realistic_beat();
    drain_results();
    write_register(CFG_DEADBAND, 13'd2048);
    write_register(CFG_SPARE, 13'h1FFF);
    send_beat(16'h8000, 16'h8000, 16'h7FFF, 1'b0);
    send_realistic_beat();
  endtask

  task automatic randomize_registers();
    int pick;
    bit wrote;
    wrote = 1'b0;
    while (!wrote) begin
      if ($urandom_range(1)) begin
        pick = $urandom_range(4);
        write_register(CFG_ALPHA, (pick == 0) ? 13'd0 : (pick == 1) ? 13'd256 :
                       (pick == 2) ? 13'($urandom_range(511)) :
                       (pick == 3) ? 13'($urandom_range(1, 64)) : 13'($urandom));
        wrote = 1'b1;
      end
      if ($urandom_range(1)) begin
        pick = $urandom_range(4);
        write_register(CFG_DEADBAND, (pick == 0) ? 13'd0 : (pick == 1) ? 13'd2048 :
                       (pick == 2) ? 13'($urandom_range(4095)) :
                       (pick == 3) ? 13'($urandom_range(64)) : 13'($urandom));
        wrote = 1'b1;
      end
      if ($urandom_range(1)) begin
        pick = $urandom_range(3);
        write_register(CFG_SCALE, (pick == 0) ? 13'd0 : (pick == 1) ? 13'd8191 :
                       (pick == 2) ? 13'd5023 : 13'($urandom));
        wrote = 1'b1;
      end
    end
  endtask

  task automatic test_random_traffic();
    int pick;
    for (int profile = 0; profile < 3; profile++) begin
      send_gap_pct = (profile == 0) ? 23 : (profile == 1) ? 61 : 0;
      recv_stall_pct = (profile == 0) ? 61 : (profile == 1) ? 23 : 0;
      for (int phase = 0; phase < 6; phase++) begin
        drain_results();
        randomize_registers();
        for (int n = 0; n < 72; n++) begin
          pick = $urandom_range(99);
          if (pick < 8) send_beat(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
          else if (pick < 23) send_noise_beat();
          else send_realistic_beat();
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_AXES; i++) begin
      filt_state[i] = 0;
      offset_mag[i] = 0;
      cal_sum[i] = 0;
    end
    cal_count = 0;
    running = 1'b0;
    alpha_reg = int'(ALPHA_RESET);
    deadband_reg = int'(LIMIT_RESET);
    scale_reg = int'(SCALE_RESET);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_gap_pct = 23;
    recv_stall_pct = 61;
    test_calibration();
    test_reset_registers();
    test_word_extremes();
    test_register_extremes();
    test_random_traffic();

    drain_results();
    // Let any stray result beat surface before the verdict.
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
